// File: rtl/core/tkmk_pkg.sv
// ----------------------------------------------------------------------------
// tkmk_pkg
// Types and constants shared by the top-k match keeper modules.
// ----------------------------------------------------------------------------
package tkmk_pkg;

  localparam int SCORE_W  = 16;
  localparam int DEPTH_W  = 16;
  localparam int YAWR_W   = 16;
  localparam int ANGLE_W  = 17;
  localparam int LOC_W    = 12;
  localparam int TORG_W   = 13;
  localparam int ORIGIN_W = 14;
  localparam int CFG_W    = 5;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 112;

  // Yaw remap thresholds in hundredths of a degree.
  localparam logic [YAWR_W-1:0] YAW_HALF_TURN = 16'd18000;
  localparam logic [17:0]       YAW_FULL_TURN = 18'd36000;

  localparam logic [CFG_W-1:0] KEEP_COUNT_RESET = 5'd16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic FUNC_OFFER = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic signed [ORIGIN_W-1:0] origin_y;
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ANGLE_W-1:0]  roll;
    logic signed [ANGLE_W-1:0]  pitch;
    logic signed [ANGLE_W-1:0]  yaw;
    logic        [DEPTH_W-1:0]  depth;
    logic signed [SCORE_W-1:0]  score;
  } entry_t;

  typedef struct packed {
    logic   func;
    entry_t entry;
  } qitem_t;

endpackage

// File: rtl/core/top_k_match_keeper.sv
// ----------------------------------------------------------------------------
// top_k_match_keeper
// Keeps the best-scoring pose candidates up to a configured count and drains
// them in ascending score order on request.
// ----------------------------------------------------------------------------
// Flow: an accepted item is registered in the queue before it reaches the chain;
//   a drain's results are registered in the output register.
//   The chain takes an offer whenever one heads the queue; a drain hands its
//   kept entries out one at a time through the single output register, which can stall it.
// Reset: rst is synchronous and active high; it empties the queue and the
//   chain, drops any result held in the output register and sets keep_count
//   back to 16.
// ----------------------------------------------------------------------------
module top_k_match_keeper #(
  parameter int MAX_KEEP = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: keep_count register.
  input  logic                            cfg_we,
  input  logic [tkmk_pkg::CFG_W-1:0]      cfg_wdata,
  // Input items.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata from bit 0: score, depth_code, yaw_raw, pitch_in, roll_in, loc_x,
  // loc_y, templ_org_x, templ_org_y, zero fill.
  input  logic [tkmk_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser: func (0 offers a candidate, 1 drains).
  input  logic                            s_tuser,
  // Result items.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata from bit 0: out_score, out_depth, out_yaw, out_pitch, out_roll,
  // out_origin_x, out_origin_y, zero fill.
  output logic [tkmk_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tlast: last, set on the final entry of a drain.
  output logic                            m_tlast
);
  import tkmk_pkg::*;

  logic [CFG_W-1:0] keep_count;
  logic             push_valid;
  logic             push_ready;
  qitem_t           push_item;
  logic             pop_valid;
  logic             pop_ready;
  qitem_t           pop_item;
  entry_t           m_entry;

  // The user must write the limit register only while the block is idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_COUNT_RESET;
    end else if (cfg_we) begin
      keep_count <= cfg_wdata;
    end
  end

  // The front converts the pose and classifies each item as offer or drain.
  tkmk_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // The queue lets the front keep taking items while a drain is in progress.
  tkmk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // The chain holds kept entries sorted by score, ties in arrival order, so
  // its head is always the entry to evict or to drain first.
  tkmk_chain #(
    .MAX_KEEP (MAX_KEEP)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .keep_count (keep_count),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .m_entry    (m_entry),
    .m_last     (m_tlast)
  );

  assign m_tdata = {1'b0, m_entry.origin_y, m_entry.origin_x, m_entry.roll,
                    m_entry.pitch, m_entry.yaw, m_entry.depth, m_entry.score};

endmodule

// File: rtl/core/tkmk_front.sv
// ----------------------------------------------------------------------------
// tkmk_front
// Accepts input items, converts the raw pose into the kept form and pushes
// the classified item into the command queue.
// ----------------------------------------------------------------------------
module tkmk_front (
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tkmk_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  output logic                            push_valid,
  input  logic                            push_ready,
  output tkmk_pkg::qitem_t                push_item
);
  import tkmk_pkg::*;

  logic        [SCORE_W-1:0] score;
  logic        [DEPTH_W-1:0] depth;
  logic        [YAWR_W-1:0]  yaw_raw;
  logic        [ANGLE_W-1:0] pitch;
  logic        [ANGLE_W-1:0] roll;
  logic        [LOC_W-1:0]   loc_x;
  logic        [LOC_W-1:0]   loc_y;
  logic        [TORG_W-1:0]  torg_x;
  logic        [TORG_W-1:0]  torg_y;
  logic signed [17:0]        yaw_wide;

  assign score   = s_tdata[15:0];
  assign depth   = s_tdata[31:16];
  assign yaw_raw = s_tdata[47:32];
  assign pitch   = s_tdata[64:48];
  assign roll    = s_tdata[81:65];
  assign loc_x   = s_tdata[93:82];
  assign loc_y   = s_tdata[105:94];
  assign torg_x  = s_tdata[118:106];
  assign torg_y  = s_tdata[131:119];

  // Above a half turn the yaw wraps to raw minus a full turn, else it negates.
  always_comb begin
    if (yaw_raw > YAW_HALF_TURN) begin
      yaw_wide = $signed({2'b00, yaw_raw}) - $signed(YAW_FULL_TURN);
    end else begin
      yaw_wide = -$signed({2'b00, yaw_raw});
    end
  end

  always_comb begin
    push_item.func           = s_tuser;
    push_item.entry.score    = score;
    push_item.entry.depth    = depth;
    push_item.entry.yaw      = yaw_wide[ANGLE_W-1:0];
    push_item.entry.pitch    = pitch;
    push_item.entry.roll     = roll;
    push_item.entry.origin_x = $signed({2'b00, loc_x}) + $signed({torg_x[TORG_W-1], torg_x});
    push_item.entry.origin_y = $signed({2'b00, loc_y}) + $signed({torg_y[TORG_W-1], torg_y});
  end

  assign push_valid = s_tvalid;
  assign s_tready   = push_ready;

endmodule

// File: rtl/core/tkmk_queue.sv
// ----------------------------------------------------------------------------
// tkmk_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module tkmk_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  tkmk_pkg::qitem_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output tkmk_pkg::qitem_t pop_item
);
  import tkmk_pkg::*;

  qitem_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/tkmk_chain.sv
// ----------------------------------------------------------------------------
// tkmk_chain
// Sorted chain of cells that keeps the best entries and drains them in
// ascending score order through an output register.
// ----------------------------------------------------------------------------
module tkmk_chain #(
  parameter int MAX_KEEP = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [tkmk_pkg::CFG_W-1:0]      keep_count,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  tkmk_pkg::qitem_t                pop_item,
  output logic                            m_valid,
  input  logic                            m_ready,
  output tkmk_pkg::entry_t                m_entry,
  output logic                            m_last
);
  import tkmk_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEEP + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  entry_t             cells      [MAX_KEEP];
  entry_t             cells_next [MAX_KEEP];
  logic [MAX_KEEP-1:0] gt;
  logic [MAX_KEEP-1:0] le_ins;
  logic [MAX_KEEP-1:0] le_rep;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CFG_W-1:0]   lim_cfg;
  logic               full;
  logic               head_offer;
  logic               head_drain;
  logic               do_insert;
  logic               do_replace;
  logic               out_free;
  logic               emit;
  entry_t             cand;

  assign cand       = pop_item.entry;
  assign head_offer = pop_valid && (pop_item.func == FUNC_OFFER);
  assign head_drain = pop_valid && (pop_item.func == FUNC_DRAIN);
  assign out_free   = !m_valid || m_ready;
  assign emit       = head_drain && (count != '0) && out_free;

  assign lim_cfg = (keep_count == '0) ? CFG_W'(1) : keep_count;
  assign full    = (count >= CNT_W'(MAX_KEEP)) || (CMP_W'(count) >= CMP_W'(lim_cfg));

  assign do_insert  = head_offer && !full;
  assign do_replace = head_offer && full && (count != '0) &&
                      (cand.score > cells[0].score);

  assign pop_ready = (pop_item.func == FUNC_OFFER) || (count == '0) ||
                     (out_free && (count == CNT_W'(1)));

  // gt marks kept cells that score above the candidate; the chain is sorted,
  // so the marks form one run up to the fill.
  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      gt[i]     = (CNT_W'(i) < count) && (cells[i].score > cand.score);
      le_ins[i] = (CNT_W'(i) >= count) || gt[i];
    end
    for (int j = 0; j < MAX_KEEP; j++) begin
      if (j == MAX_KEEP - 1) begin
        le_rep[j] = 1'b1;
      end else begin
        le_rep[j] = (CNT_W'(j + 1) >= count) || gt[j + 1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      cells_next[i] = cells[i];
      if (emit) begin
        if (i < MAX_KEEP - 1) begin
          cells_next[i] = cells[i + 1];
        end
      end else if (do_insert) begin
        if (le_ins[i]) begin
          if (i > 0 && le_ins[(i > 0) ? i - 1 : 0]) begin
            cells_next[i] = cells[(i > 0) ? i - 1 : 0];
          end else begin
            cells_next[i] = cand;
          end
        end
      end else if (do_replace) begin
        // Head leaves, the rest slide down, the candidate takes its place.
        if (le_rep[i]) begin
          if (i > 0 && le_rep[(i > 0) ? i - 1 : 0]) begin
            cells_next[i] = cells[i];
          end else begin
            cells_next[i] = cand;
          end
        end else if (i < MAX_KEEP - 1) begin
          cells_next[i] = cells[i + 1];
        end
      end
    end
  end

  always_comb begin
    count_next = count;
    if (emit) begin
      count_next = count - 1'b1;
    end else if (do_insert) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      cells[i] <= cells_next[i];
    end
    if (emit) begin
      m_entry <= cells[0];
      m_last  <= (count == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      m_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (emit) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_KEEP))
    else $error("kept count above capacity");

  a_emit_nonempty : assert property (@(posedge clk) disable iff (rst)
    emit |-> (count != '0) && !do_insert && !do_replace)
    else $error("emit from an empty chain or mixed with an offer");

  a_last_empties : assert property (@(posedge clk) disable iff (rst)
    (emit && (count == CNT_W'(1))) |=> (count == '0) && m_valid && m_last)
    else $error("final drained entry did not empty the chain");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    (m_valid && !m_ready) |=> m_valid && $stable(m_entry) && $stable(m_last))
    else $error("output register changed while stalled");

endmodule

// File: verif/top_k_match_keeper_tb.sv
// ----------------------------------------------------------------------------
// top_k_match_keeper_tb
// Self-checking testbench for the top-k match keeper. Offers and drains are
// streamed in bursts with random gaps while the result side stalls on its own
// pattern. A behavioral model of the sorted store predicts every drained
// match, and each result item is compared field by field, in order.
// ----------------------------------------------------------------------------
module top_k_match_keeper_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tkmk_pkg::*;

  localparam int MAX_KEEP    = 16;
  localparam int RANDOM_GOAL = 245;
  // Cycles allowed for queued offers to settle after the last drain result.
  localparam int IDLE_TAIL   = 16;

  // One candidate as it travels on s_tdata.
  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic        [DEPTH_W-1:0] depth;
    logic        [YAWR_W-1:0]  yaw_raw;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] roll;
    logic        [LOC_W-1:0]   loc_x;
    logic        [LOC_W-1:0]   loc_y;
    logic signed [TORG_W-1:0]  torg_x;
    logic signed [TORG_W-1:0]  torg_y;
  } candidate_t;

  // One drained match as it is expected on m_tdata and m_tlast.
  typedef struct {
    entry_t match;
    logic   last;
  } drained_match_t;

  // The result side cycles through these stall behaviors.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT_STALL,
    RX_HEAVY_STALL,
    RX_PERIODIC
  } rx_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  // s_tdata from bit 0: score, depth_code, yaw_raw, pitch_in, roll_in, loc_x,
  // loc_y, templ_org_x, templ_org_y, zero fill.
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  // s_tuser: func.
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  // m_tdata from bit 0: out_score, out_depth, out_yaw, out_pitch, out_roll,
  // out_origin_x, out_origin_y, zero fill.
  logic [OUT_DATA_W-1:0] m_tdata;
  // m_tlast: last.
  logic                  m_tlast;

  // Model of the store: kept matches sorted by score, ties in arrival order,
  // so the head is always the entry that an offer would push out.
  entry_t         kept_matches[$];
  drained_match_t pending_results[$];
  logic [CFG_W-1:0] keep_setting = KEEP_COUNT_RESET;

  int mismatch_count = 0;
  int offers_sent    = 0;
  int drains_sent    = 0;
  int matches_seen   = 0;
  int settings_used  = 0;

  // Sender burst state. valid_on mirrors what has been scheduled on s_tvalid,
  // so that it is never lowered twice in the same time step.
  int burst_left = 0;
  bit valid_on   = 1'b0;

  rx_mode_t rx_mode  = RX_OPEN;
  int       rx_epoch = 0;
  int       rx_tick  = 0;

  top_k_match_keeper #(
    .MAX_KEEP (MAX_KEEP)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the store
  // --------------------------------------------------------------------------

  // A keep_count of zero still keeps one match; anything above the store
  // size is clipped to it.
  function automatic int effective_limit();
    if (keep_setting == 0) return 1;
    if (keep_setting > MAX_KEEP) return MAX_KEEP;
    return keep_setting;
  endfunction

  // New matches go behind every kept match of equal score.
  function automatic void insert_by_score(entry_t e);
    int pos = 0;
    while (pos < kept_matches.size() && kept_matches[pos].score <= e.score) pos++;
    kept_matches.insert(pos, e);
  endfunction

  function automatic void predict_item(logic func, candidate_t c);
    entry_t         e;
    drained_match_t result;
    int             yaw;
    int             org_x;
    int             org_y;
    if (func == FUNC_DRAIN) begin
      foreach (kept_matches[i]) begin
        result.match = kept_matches[i];
        result.last  = (i == kept_matches.size() - 1);
        pending_results.insert(pending_results.size(), result);
      end
      kept_matches.delete();
      return;
    end
    // Yaw above half a turn wraps to raw minus a full turn, otherwise it is
    // negated. Raw codes beyond a full turn follow the same rule.
    if (int'(c.yaw_raw) > int'(YAW_HALF_TURN))
      yaw = int'(c.yaw_raw) - int'(YAW_FULL_TURN);
    else
      yaw = -int'(c.yaw_raw);
    org_x = int'(c.loc_x) + int'(c.torg_x);
    org_y = int'(c.loc_y) + int'(c.torg_y);
    e.score    = c.score;
    e.depth    = c.depth;
    e.yaw      = yaw[ANGLE_W-1:0];
    e.pitch    = c.pitch;
    e.roll     = c.roll;
    e.origin_x = org_x[ORIGIN_W-1:0];
    e.origin_y = org_y[ORIGIN_W-1:0];
    if (kept_matches.size() < effective_limit()) begin
      insert_by_score(e);
    end else if (kept_matches.size() > 0 && e.score > kept_matches[0].score) begin
      // Strictly better than the weakest kept match: it takes its place.
      void'(kept_matches.pop_front());
      insert_by_score(e);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Narrow scores crowd into a few values so that ties are common.
  function automatic candidate_t random_candidate(bit narrow);
    candidate_t c;
    c.score   = narrow ? SCORE_W'($urandom_range(0, 6) - 3) : SCORE_W'($urandom);
    c.depth   = DEPTH_W'($urandom);
    c.yaw_raw = ($urandom_range(0, 15) == 0) ? YAWR_W'($urandom)
                                             : YAWR_W'($urandom_range(0, 36000));
    c.pitch   = ANGLE_W'(int'($urandom_range(0, 72000)) - 36000);
    c.roll    = ANGLE_W'(int'($urandom_range(0, 72000)) - 36000);
    c.loc_x   = LOC_W'($urandom);
    c.loc_y   = LOC_W'($urandom);
    c.torg_x  = TORG_W'($urandom);
    c.torg_y  = TORG_W'($urandom);
    return c;
  endfunction

  // Called right after a rising edge. Holds the item until it is accepted,
  // feeds it to the model, then possibly opens a gap before the next one.
  task automatic send_item(logic func, candidate_t c);
    int gap;
    s_tvalid <= 1'b1;
    valid_on = 1'b1;
    s_tuser  <= func;
    s_tdata  <= {4'b0, c.torg_y, c.torg_x, c.loc_y, c.loc_x, c.roll, c.pitch,
                 c.yaw_raw, c.depth, c.score};
    do @(posedge clk); while (!s_tready);
    predict_item(func, c);
    if (func == FUNC_DRAIN) drains_sent++;
    else offers_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 7);
      // Now and then a long burst runs with no idling at all.
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        valid_on = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_drain();
    send_item(FUNC_DRAIN, random_candidate(1'b0));
  endtask

  // Stops sending and waits until every drained match has come out, then
  // leaves time for offers still queued inside the block to be absorbed.
  task automatic wait_for_idle();
    if (valid_on) begin
      s_tvalid <= 1'b0;
      valid_on = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic set_keep_count(logic [CFG_W-1:0] value);
    wait_for_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    keep_setting = value;
    settings_used++;
  endtask

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  // Every accepted result is matched against the oldest expected match.
  always @(posedge clk) begin : check_results
    drained_match_t want;
    entry_t         got;
    if (!rst && m_tvalid && m_tready) begin
      got = entry_t'(m_tdata[$bits(entry_t)-1:0]);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected match, score %0d", got.score));
      end else begin
        want = pending_results.pop_front();
        if (got.score !== want.match.score)
          report_mismatch($sformatf("score got %0d want %0d", got.score,
                                    want.match.score));
        if (got.depth !== want.match.depth)
          report_mismatch($sformatf("depth got %0d want %0d", got.depth,
                                    want.match.depth));
        if (got.yaw !== want.match.yaw)
          report_mismatch($sformatf("yaw got %0d want %0d", got.yaw,
                                    want.match.yaw));
        if (got.pitch !== want.match.pitch)
          report_mismatch($sformatf("pitch got %0d want %0d", got.pitch,
                                    want.match.pitch));
        if (got.roll !== want.match.roll)
          report_mismatch($sformatf("roll got %0d want %0d", got.roll,
                                    want.match.roll));
        if (got.origin_x !== want.match.origin_x)
          report_mismatch($sformatf("origin_x got %0d want %0d", got.origin_x,
                                    want.match.origin_x));
        if (got.origin_y !== want.match.origin_y)
          report_mismatch($sformatf("origin_y got %0d want %0d", got.origin_y,
                                    want.match.origin_y));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last got %b want %b", m_tlast, want.last));
      end
      matches_seen++;
    end
  end

  // The result side stalls in epochs of random length, each with its own
  // behavior: always ready, lightly or heavily stalled, or a fixed rhythm.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_epoch == 0) begin
      rx_mode  <= rx_mode_t'($urandom_range(0, 3));
      rx_epoch <= $urandom_range(30, 120);
    end else begin
      rx_epoch <= rx_epoch - 1;
    end
    case (rx_mode)
      RX_OPEN:        m_tready <= 1'b1;
      RX_LIGHT_STALL: m_tready <= ($urandom_range(0, 9) < 7);
      RX_HEAVY_STALL: m_tready <= ($urandom_range(0, 9) < 2);
      default:        m_tready <= (rx_tick % 8) < 3;
    endcase
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Straight out of reset the limit is sixteen. A drain of the empty store
  // must stay silent; then field extremes and every yaw branch are offered and drained.
  task automatic test_reset_and_extremes();
    candidate_t c;
    send_drain();
    c = random_candidate(1'b0);
    c.score = -32768; c.depth = 0;     c.yaw_raw = 0;
    c.pitch = -36000; c.roll = 36000;  c.loc_x = 0;    c.loc_y = 4095;
    c.torg_x = -4096; c.torg_y = 4095;
    send_item(FUNC_OFFER, c);
    c.score = 32767;  c.depth = 16'hFFFF; c.yaw_raw = 18000;
    c.pitch = 36000;  c.roll = -36000; c.loc_x = 4095; c.loc_y = 0;
    c.torg_x = 4095;  c.torg_y = -4096;
    send_item(FUNC_OFFER, c);
    c = random_candidate(1'b0);
    c.score = 0; c.yaw_raw = 18001;
    send_item(FUNC_OFFER, c);
    c = random_candidate(1'b0);
    c.yaw_raw = 36000;
    send_item(FUNC_OFFER, c);
    // Raw yaw codes past a full turn.
    c = random_candidate(1'b0);
    c.yaw_raw = 16'hFFFF;
    send_item(FUNC_OFFER, c);
    send_drain();
  endtask

  // Equal scores come out in arrival order; a tie with the weakest match is
  // refused once the store is full, a better score evicts it.
  task automatic test_tie_order();
    candidate_t c;
    set_keep_count(3);
    for (int i = 0; i < 4; i++) begin
      c = random_candidate(1'b0);
      c.score = 5;
      send_item(FUNC_OFFER, c);
    end
    c = random_candidate(1'b0);
    c.score = 6;
    send_item(FUNC_OFFER, c);
    send_drain();
  endtask

  // Lowering the limit under the current fill evicts nothing by itself; the
  // store counts as full and only a better offer swaps one entry.
  task automatic test_limit_lowered();
    candidate_t c;
    set_keep_count(CFG_W'(MAX_KEEP));
    for (int i = 0; i < 6; i++) begin
      c = random_candidate(1'b0);
      c.score = SCORE_W'(10 + i);
      send_item(FUNC_OFFER, c);
    end
    set_keep_count(2);
    c = random_candidate(1'b0);
    c.score = 9;
    send_item(FUNC_OFFER, c);
    c.score = 10;
    send_item(FUNC_OFFER, c);
    c.score = 30;
    send_item(FUNC_OFFER, c);
    send_drain();
  endtask

  // Phases of random offers under a fresh limit each, mostly closed by a
  // drain. Some phases leave the store filled so that the next limit lands
  // on a partly full store. Stray drains are mixed in as noise.
  task automatic test_random_phases();
    int sent = 0;
    int offers;
    bit narrow;
    logic [CFG_W-1:0] limit;
    while (sent < RANDOM_GOAL) begin
      case ($urandom_range(0, 9))
        0:       limit = 0;
        1:       limit = 5'd31;
        2:       limit = 1;
        3:       limit = CFG_W'(MAX_KEEP);
        4:       limit = CFG_W'($urandom_range(MAX_KEEP + 1, 30));
        default: limit = CFG_W'($urandom_range(2, MAX_KEEP - 1));
      endcase
      set_keep_count(limit);
      narrow = ($urandom_range(0, 2) == 0);
      offers = $urandom_range(0, 28);
      for (int i = 0; i < offers; i++) begin
        if ($urandom_range(0, 24) == 0) send_drain();
        else send_item(FUNC_OFFER, random_candidate(narrow));
        sent++;
      end
      if ($urandom_range(0, 6) != 0) begin
        send_drain();
        sent++;
      end
    end
    send_drain();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_and_extremes();
    test_tie_order();
    test_limit_lowered();
    test_random_phases();
    wait_for_idle();
    $display("Run sent %0d offers and %0d drains under %0d keep_count writes,",
             offers_sent, drains_sent, settings_used);
    $display("and compared %0d drained matches against the model.", matches_seen);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("top_k_match_keeper_tb: clean");
    end else begin
      $display("top_k_match_keeper_tb: errors");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #5_000_000;
    $display("Run timed out with %0d matches still expected.", pending_results.size());
    $display("top_k_match_keeper_tb: errors");
    $finish;
  end

endmodule
